@@ design/salc_pkg.sv @@
// salc_pkg: shared types and constants for the set-associative LRU cache model.
// Geometry, request codes and the per-set row layouts of the tag and state memories.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

  localparam int ADDR_W     = 32;
  localparam int SETS       = 512;
  localparam int WAYS       = 2;
  localparam int SET_BITS   = $clog2(SETS);
  localparam int WAY_BITS   = 1;
  // shift amount may be as low as zero, so keep every bit above the set index
  localparam int TAG_W      = ADDR_W - SET_BITS;
  localparam int SHIFT_W    = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 1;

  localparam logic [SHIFT_W-1:0]    LINE_OFFSET_RESET = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_OFFSET   = 1'b0;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  // per-set replacement state: valid per way, and the least recent way
  typedef struct packed {
    logic [WAYS-1:0]     valid;
    logic [WAY_BITS-1:0] lru_way;
  } meta_t;

  typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;

endpackage

`default_nettype wire

@@ design/set_assoc_lru_cache_model_core.sv @@
// set_assoc_lru_cache_model_core: top level of the cache hit/miss model.
// Holds the config register, the tag and state memories and the lookup pipeline.
// Depends on salc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Two-way, 512-set hit/miss model with exact LRU. One lookup is accepted per
// cycle while in_tready is high; its result passes from the lookup stage to
// the output register. The set comes from the index address and the tag from
// the tag address, both shifted right by line_offset_bits. The tag and state
// memories are read at the accepting edge and written by the following stage,
// with a bypass for back-to-back accesses to one set. A flush returns hit=0/way=0;
// in_tready stays low while the flush waits in the lookup stage and then during
// a clearing pass over all 512 sets of the state memory, one set per cycle; the
// same pass runs after reset. Write line_offset_bits only while the block is idle.
module set_assoc_lru_cache_model_core
  import salc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [63:0]           in_tdata,   // [31:0] tag addr, [63:32] index addr
  input  wire logic [0:0]            in_tuser,   // [0] req_type
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata,  // [0] hit, [1] way, [7:2] zero
  // configuration
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  // ---------------- configuration ----------------
  logic [SHIFT_W-1:0] line_offset_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_offset_r <= LINE_OFFSET_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_LINE_OFFSET) begin
      line_offset_r <= cfg_pwdata[SHIFT_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == REG_LINE_OFFSET) begin
      cfg_prdata = {{(CFG_DATA_W-SHIFT_W){1'b0}}, line_offset_r};
    end
  end

  // ---------------- input decode ----------------
  logic [ADDR_W-1:0]   tag_lnum;
  logic [ADDR_W-1:0]   idx_lnum;
  logic [SET_BITS-1:0] in_set;
  logic [TAG_W-1:0]    in_tag;
  logic                in_acc;

  assign tag_lnum = in_tdata[ADDR_W-1:0] >> line_offset_r;
  assign idx_lnum = in_tdata[2*ADDR_W-1:ADDR_W] >> line_offset_r;
  assign in_set   = idx_lnum[SET_BITS-1:0];
  assign in_tag   = tag_lnum[ADDR_W-1:SET_BITS];
  assign in_acc   = in_tvalid && in_tready;

  // ---------------- pipeline control ----------------
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_flush_r;
  logic [SET_BITS-1:0] s1_set_r;
  logic [TAG_W-1:0]    s1_tag_r;
  logic                s1_adv;
  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r;
  logic [WAY_BITS-1:0] out_way_r;
  logic                clr_r, clr_nxt;
  logic [SET_BITS-1:0] clr_cnt_r, clr_cnt_nxt;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_r && !(s1_valid_r && s1_flush_r) && (!s1_valid_r || s1_adv);

  // ---------------- memories ----------------
  tag_row_t tag_mem [SETS];
  meta_t    meta_mem [SETS];

  tag_row_t tag_rd_r;
  meta_t    meta_rd_r;
  logic     fwd_r;
  tag_row_t fwd_tags_r;
  meta_t    fwd_meta_r;

  tag_row_t            tags_cur, tags_new;
  meta_t               meta_cur, meta_new;
  logic                tag_we, meta_we, acc_we;
  logic [SET_BITS-1:0] meta_waddr;
  meta_t               meta_wdata;
  logic [WAYS-1:0]     way_hit;
  logic                out_hit_nxt;
  logic [WAY_BITS-1:0] out_way_nxt;
  logic [WAY_BITS-1:0] victim;

  assign acc_we     = s1_adv && !s1_flush_r;
  assign tag_we     = acc_we && !out_hit_nxt;
  assign meta_we    = clr_r || acc_we;
  assign meta_waddr = clr_r ? clr_cnt_r : s1_set_r;
  assign meta_wdata = clr_r ? meta_t'('0) : meta_new;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[s1_set_r] <= tags_new;
    end
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (in_acc) begin
      tag_rd_r  <= tag_mem[in_set];
      meta_rd_r <= meta_mem[in_set];
    end
  end

  // the stage ahead may write the set being read at the same edge
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_r      <= acc_we && (s1_set_r == in_set);
      fwd_tags_r <= tags_new;
      fwd_meta_r <= meta_new;
    end
  end

  // ---------------- lookup and replacement ----------------
  assign tags_cur = fwd_r ? fwd_tags_r : tag_rd_r;
  assign meta_cur = fwd_r ? fwd_meta_r : meta_rd_r;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      way_hit[w] = meta_cur.valid[w] && (tags_cur[w] == s1_tag_r);
    end
    if (!meta_cur.valid[0]) begin
      victim = 1'b0;
    end else if (!meta_cur.valid[1]) begin
      victim = 1'b1;
    end else begin
      victim = meta_cur.lru_way;
    end

    if (s1_flush_r) begin
      out_hit_nxt = 1'b0;
      out_way_nxt = '0;
    end else if (way_hit[0]) begin
      out_hit_nxt = 1'b1;
      out_way_nxt = 1'b0;
    end else if (way_hit[1]) begin
      out_hit_nxt = 1'b1;
      out_way_nxt = 1'b1;
    end else begin
      out_hit_nxt = 1'b0;
      out_way_nxt = victim;
    end

    meta_new                      = meta_cur;
    meta_new.valid[out_way_nxt]   = 1'b1;
    meta_new.lru_way              = ~out_way_nxt;
    tags_new                      = tags_cur;
    if (!out_hit_nxt) begin
      tags_new[out_way_nxt] = s1_tag_r;
    end
  end

  // ---------------- control next state ----------------
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    clr_nxt       = clr_r;
    clr_cnt_nxt   = clr_cnt_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      s1_valid_nxt  = 1'b0;
      if (s1_flush_r) begin
        clr_nxt     = 1'b1;
        clr_cnt_nxt = '0;
      end
    end
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end
    if (clr_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == SET_BITS'(SETS - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      clr_r       <= clr_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_flush_r <= (in_tuser[0] == REQ_FLUSH);
      s1_set_r   <= in_set;
      s1_tag_r   <= in_tag;
    end
    if (s1_adv) begin
      out_hit_r <= out_hit_nxt;
      out_way_r <= out_way_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_way_r, out_hit_r};

endmodule

`default_nettype wire
